### design/pcb_pkg.sv
// shared constants and register codes for the particle cylinder boundary unit
`default_nettype none

package pcb_pkg;

  localparam int DEF_WORD_BITS = 32;
  localparam int DEF_FRAC_BITS = 16;
  localparam int CFG_ADDR_BITS = 3;
  localparam int RADIUS_DIV    = 10;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_LENGTH_X = 3'd0,
    REG_LENGTH_Y = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_RADIUS   = 3'd4
  } cfg_reg_t;

endpackage

`default_nettype wire

### design/particle_cylinder_boundary_unit.sv
// particle cylinder boundary unit: domain test, periodic wrap, projection and reflection
//
// Usage: one particle (in_pos_x, in_pos_y, in_vel_x, in_vel_y) is taken per
// transaction on the input channel (in_valid / in_stall), and one result
// (out_in_domain, out_new_x, out_new_y, out_new_vx, out_new_vy) leaves per
// transaction on the output channel (out_valid / out_stall).
// Registers are written through cfg_we / cfg_addr / cfg_wdata; the user must write them
// only while the unit holds no particle in flight; the unit does not enforce this.
// Throughput: one particle per cycle while out_stall does not hold the pipeline.
// The pipeline depth is set by the bit-per-stage square root and the two
// bit-per-stage normal dividers.
// Reset clears all stage valid bits and loads the register defaults
// (x extent and y period 1.0, centre (0.25, 0.5), radius 0.1).
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall is raised in the same cycle; nothing is lost or repeated.
`default_nettype none

module particle_cylinder_boundary_unit
  import pcb_pkg::*;
#(
  parameter int WORD_BITS = DEF_WORD_BITS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic signed [WORD_BITS-1:0] in_pos_x,
  input  wire logic signed [WORD_BITS-1:0] in_pos_y,
  input  wire logic signed [WORD_BITS-1:0] in_vel_x,
  input  wire logic signed [WORD_BITS-1:0] in_vel_y,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_in_domain,
  output logic signed [WORD_BITS-1:0]      out_new_x,
  output logic signed [WORD_BITS-1:0]      out_new_y,
  output logic signed [WORD_BITS-1:0]      out_new_vx,
  output logic signed [WORD_BITS-1:0]      out_new_vy,
  input  wire logic                        cfg_we,
  input  wire logic [CFG_ADDR_BITS-1:0]    cfg_addr,
  input  wire logic [WORD_BITS-2:0]        cfg_wdata
);

  localparam int W     = WORD_BITS;
  localparam int CW    = W - 1;
  localparam int NORM  = W - 2;
  localparam int NS    = $clog2(W - 1);
  localparam int SQ    = 4 + NS;
  localparam int SUM   = SQ + 1;
  localparam int SQEND = SUM + W;
  localparam int DIV0  = SQEND + 1;
  localparam int PN    = DIV0 + W;
  localparam int MUL   = PN + 1;
  localparam int R1    = MUL + 1;
  localparam int R2    = R1 + 1;
  localparam int M2    = R2 + 1;
  localparam int R3    = M2 + 1;
  localparam int OUT   = R3 + 1;

  localparam logic [CW-1:0] LX_RST = CW'(64'd1 << FRAC_BITS);
  localparam logic [CW-1:0] LY_RST = CW'(64'd1 << FRAC_BITS);
  localparam logic [CW-1:0] CX_RST = CW'((64'd1 << FRAC_BITS) / 4);
  localparam logic [CW-1:0] CY_RST = CW'((64'd1 << FRAC_BITS) / 2);
  localparam logic [CW-1:0] R_RST  = CW'(((64'd1 << FRAC_BITS) + 5) / RADIUS_DIV);

  localparam logic signed [W+3:0] SAT_MAX = {5'b00000, {(W-1){1'b1}}};
  localparam logic signed [W+3:0] SAT_MIN = {5'b11111, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] N_ONE   = {2'b01, {(W-2){1'b0}}};

  typedef struct packed {
    logic                    dom;
    logic                    pre;
    logic                    hit;
    logic                    center;
    logic signed [W-1:0]     x;
    logic signed [W-1:0]     y;
    logic signed [W-1:0]     vx;
    logic signed [W-1:0]     vy;
    logic signed [W:0]       dx;
    logic signed [W:0]       dy;
    logic [W-2:0]            adx;
    logic [W-2:0]            ady;
    logic [W-2:0]            m;
    logic [2*W-3:0]          sqx;
    logic [2*W-3:0]          sqy;
    logic signed [W-1:0]     sx;
    logic signed [W-1:0]     sy;
    logic [2*W-1:0]          sqn;
    logic [W+1:0]            srem;
    logic [W-1:0]            root;
    logic [W-2:0]            dnx;
    logic [W-2:0]            dny;
    logic [W-1:0]            drx;
    logic [W-1:0]            dry;
    logic [W-2:0]            qx;
    logic [W-2:0]            qy;
    logic signed [W-1:0]     nx;
    logic signed [W-1:0]     ny;
    logic signed [2*W-1:0]   pxr;
    logic signed [2*W-1:0]   pyr;
    logic signed [2*W-1:0]   pvx;
    logic signed [2*W-1:0]   pvy;
    logic signed [2*W-1:0]   vsum;
    logic signed [W+1:0]     px;
    logic signed [W+1:0]     py;
    logic signed [W+1:0]     vn;
    logic signed [2*W+1:0]   pdx;
    logic signed [2*W+1:0]   pdy;
    logic signed [W-1:0]     nvx;
    logic signed [W-1:0]     nvy;
  } pipe_t;

  logic [CW-1:0]     lx_r, ly_r, cx_r, cy_r, rad_r;
  logic [2*W-3:0]    rr_r;
  logic [OUT:0]      v_r;
  pipe_t             pipe_r   [0:OUT];
  pipe_t             pipe_nxt [0:OUT];
  logic              adv;

  function automatic logic signed [2*W+1:0] rnd_sh(input logic signed [2*W+1:0] p,
                                                   input int k);
    logic [2*W+1:0] mag;
    logic [2*W+1:0] half;
    logic [2*W+1:0] q;
    half = (2*W+2)'(1) << (k - 1);
    mag  = p[2*W+1] ? -p : p;
    q    = (mag + half) >> k;
    return p[2*W+1] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [W-1:0] sat_w(input logic signed [W+3:0] v);
    if (v > SAT_MAX) begin
      return SAT_MAX[W-1:0];
    end else if (v < SAT_MIN) begin
      return SAT_MIN[W-1:0];
    end
    return v[W-1:0];
  endfunction

  assign adv      = !(v_r[OUT] && out_stall);
  assign in_stall = !adv;

  // configuration and stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lx_r  <= LX_RST;
      ly_r  <= LY_RST;
      cx_r  <= CX_RST;
      cy_r  <= CY_RST;
      rad_r <= R_RST;
      v_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_LENGTH_X: lx_r  <= cfg_wdata;
          REG_LENGTH_Y: ly_r  <= cfg_wdata;
          REG_CENTER_X: cx_r  <= cfg_wdata;
          REG_CENTER_Y: cy_r  <= cfg_wdata;
          REG_RADIUS:   rad_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (adv) begin
        v_r <= {v_r[OUT-1:0], in_valid};
      end
    end
  end

  always_ff @(posedge clk) begin
    rr_r <= rad_r * rad_r;
    if (adv) begin
      pipe_r <= pipe_nxt;
    end
  end

  // domain test, periodic wrap, offsets from the centre
  always_comb begin : c_p0
    logic signed [W-1:0] ly_s;
    ly_s = $signed({1'b0, ly_r});
    pipe_nxt[0]     = '0;
    pipe_nxt[0].x   = in_pos_x;
    pipe_nxt[0].vx  = in_vel_x;
    pipe_nxt[0].vy  = in_vel_y;
    pipe_nxt[0].dom = !in_pos_x[W-1] && (in_pos_x < $signed({1'b0, lx_r}));
    pipe_nxt[0].y   = in_pos_y;
    if (pipe_nxt[0].dom) begin
      if (in_pos_y[W-1]) begin
        pipe_nxt[0].y = in_pos_y + ly_s;
      end else if (in_pos_y >= ly_s) begin
        pipe_nxt[0].y = in_pos_y - ly_s;
      end
    end
    pipe_nxt[0].dx = $signed({in_pos_x[W-1], in_pos_x}) - $signed({2'b00, cx_r});
    pipe_nxt[0].dy = $signed({pipe_nxt[0].y[W-1], pipe_nxt[0].y}) - $signed({2'b00, cy_r});
  end

  // magnitudes and box test
  always_comb begin : c_p1
    logic [W:0] ax;
    logic [W:0] ay;
    pipe_nxt[1] = pipe_r[0];
    ax = pipe_r[0].dx[W] ? -pipe_r[0].dx : pipe_r[0].dx;
    ay = pipe_r[0].dy[W] ? -pipe_r[0].dy : pipe_r[0].dy;
    pipe_nxt[1].adx    = ax[W-2:0];
    pipe_nxt[1].ady    = ay[W-2:0];
    pipe_nxt[1].pre    = (ax < {2'b00, rad_r}) && (ay < {2'b00, rad_r});
    pipe_nxt[1].center = (pipe_r[0].dx == '0) && (pipe_r[0].dy == '0);
    pipe_nxt[1].m      = (ax > ay) ? ax[W-2:0] : ay[W-2:0];
  end

  always_comb begin : c_p2
    pipe_nxt[2]     = pipe_r[1];
    pipe_nxt[2].sqx = pipe_r[1].adx * pipe_r[1].adx;
    pipe_nxt[2].sqy = pipe_r[1].ady * pipe_r[1].ady;
    pipe_nxt[2].sx  = pipe_r[1].dx[W-1:0];
    pipe_nxt[2].sy  = pipe_r[1].dy[W-1:0];
  end

  always_comb begin : c_p3
    pipe_nxt[3]     = pipe_r[2];
    pipe_nxt[3].hit = pipe_r[2].pre &&
                      (({1'b0, pipe_r[2].sqx} + {1'b0, pipe_r[2].sqy}) < {1'b0, rr_r});
  end

  // leading-zero normalization of the offset pair
  for (genvar k = 0; k < NS; k++) begin : g_norm
    localparam int SH = 1 << (NS - 1 - k);
    always_comb begin
      pipe_nxt[4+k] = pipe_r[3+k];
      if (pipe_r[3+k].m[W-2 -: SH] == '0) begin
        pipe_nxt[4+k].m  = pipe_r[3+k].m << SH;
        pipe_nxt[4+k].sx = pipe_r[3+k].sx <<< SH;
        pipe_nxt[4+k].sy = pipe_r[3+k].sy <<< SH;
      end
    end
  end

  always_comb begin : c_sq
    logic signed [2*W-1:0] tx;
    logic signed [2*W-1:0] ty;
    tx = pipe_r[SQ-1].sx * pipe_r[SQ-1].sx;
    ty = pipe_r[SQ-1].sy * pipe_r[SQ-1].sy;
    pipe_nxt[SQ]     = pipe_r[SQ-1];
    pipe_nxt[SQ].sqx = tx[2*W-3:0];
    pipe_nxt[SQ].sqy = ty[2*W-3:0];
  end

  always_comb begin : c_sum
    pipe_nxt[SUM]      = pipe_r[SUM-1];
    pipe_nxt[SUM].sqn  = (2*W)'(pipe_r[SUM-1].sqx) + (2*W)'(pipe_r[SUM-1].sqy);
    pipe_nxt[SUM].srem = '0;
    pipe_nxt[SUM].root = '0;
  end

  // square root, one result bit per stage
  for (genvar k = 1; k <= W; k++) begin : g_sqrt
    always_comb begin
      logic [W+3:0] rem3;
      logic [W+3:0] trial;
      logic [W+3:0] diff;
      rem3  = {pipe_r[SUM+k-1].srem, pipe_r[SUM+k-1].sqn[2*W-1 -: 2]};
      trial = {2'b00, pipe_r[SUM+k-1].root, 2'b01};
      diff  = rem3 - trial;
      pipe_nxt[SUM+k]     = pipe_r[SUM+k-1];
      pipe_nxt[SUM+k].sqn = pipe_r[SUM+k-1].sqn << 2;
      if (rem3 >= trial) begin
        pipe_nxt[SUM+k].srem = diff[W+1:0];
        pipe_nxt[SUM+k].root = {pipe_r[SUM+k-1].root[W-2:0], 1'b1};
      end else begin
        pipe_nxt[SUM+k].srem = rem3[W+1:0];
        pipe_nxt[SUM+k].root = {pipe_r[SUM+k-1].root[W-2:0], 1'b0};
      end
    end
  end

  // rounded dividend setup for the normal
  always_comb begin : c_div0
    logic signed [W-1:0] nsx;
    logic signed [W-1:0] nsy;
    logic [W-2:0]        ax;
    logic [W-2:0]        ay;
    logic [2*W-3:0]      numx;
    logic [2*W-3:0]      numy;
    nsx  = -pipe_r[SQEND].sx;
    nsy  = -pipe_r[SQEND].sy;
    ax   = pipe_r[SQEND].sx[W-1] ? nsx[W-2:0] : pipe_r[SQEND].sx[W-2:0];
    ay   = pipe_r[SQEND].sy[W-1] ? nsy[W-2:0] : pipe_r[SQEND].sy[W-2:0];
    numx = {1'b0, ax, {(W-2){1'b0}}} + (2*W-2)'(pipe_r[SQEND].root >> 1);
    numy = {1'b0, ay, {(W-2){1'b0}}} + (2*W-2)'(pipe_r[SQEND].root >> 1);
    pipe_nxt[DIV0]     = pipe_r[SQEND];
    pipe_nxt[DIV0].drx = {1'b0, numx[2*W-3:W-1]};
    pipe_nxt[DIV0].dry = {1'b0, numy[2*W-3:W-1]};
    pipe_nxt[DIV0].dnx = numx[W-2:0];
    pipe_nxt[DIV0].dny = numy[W-2:0];
    pipe_nxt[DIV0].qx  = '0;
    pipe_nxt[DIV0].qy  = '0;
  end

  // normal dividers, one quotient bit per stage
  for (genvar k = 1; k < W; k++) begin : g_div
    always_comb begin
      logic [W:0] tx;
      logic [W:0] ty;
      logic [W:0] fx;
      logic [W:0] fy;
      logic       bx;
      logic       by;
      tx = {pipe_r[DIV0+k-1].drx, pipe_r[DIV0+k-1].dnx[W-2]};
      ty = {pipe_r[DIV0+k-1].dry, pipe_r[DIV0+k-1].dny[W-2]};
      fx = tx - {1'b0, pipe_r[DIV0+k-1].root};
      fy = ty - {1'b0, pipe_r[DIV0+k-1].root};
      bx = (tx >= {1'b0, pipe_r[DIV0+k-1].root});
      by = (ty >= {1'b0, pipe_r[DIV0+k-1].root});
      pipe_nxt[DIV0+k]     = pipe_r[DIV0+k-1];
      pipe_nxt[DIV0+k].drx = bx ? fx[W-1:0] : tx[W-1:0];
      pipe_nxt[DIV0+k].dry = by ? fy[W-1:0] : ty[W-1:0];
      pipe_nxt[DIV0+k].dnx = pipe_r[DIV0+k-1].dnx << 1;
      pipe_nxt[DIV0+k].dny = pipe_r[DIV0+k-1].dny << 1;
      pipe_nxt[DIV0+k].qx  = {pipe_r[DIV0+k-1].qx[W-3:0], bx};
      pipe_nxt[DIV0+k].qy  = {pipe_r[DIV0+k-1].qy[W-3:0], by};
    end
  end

  always_comb begin : c_pn
    pipe_nxt[PN]    = pipe_r[PN-1];
    pipe_nxt[PN].nx = pipe_r[PN-1].sx[W-1] ? -$signed({1'b0, pipe_r[PN-1].qx})
                                           : $signed({1'b0, pipe_r[PN-1].qx});
    pipe_nxt[PN].ny = pipe_r[PN-1].sy[W-1] ? -$signed({1'b0, pipe_r[PN-1].qy})
                                           : $signed({1'b0, pipe_r[PN-1].qy});
  end

  always_comb begin : c_mul
    pipe_nxt[MUL]     = pipe_r[PN];
    pipe_nxt[MUL].pxr = pipe_r[PN].nx * $signed({1'b0, rad_r});
    pipe_nxt[MUL].pyr = pipe_r[PN].ny * $signed({1'b0, rad_r});
    pipe_nxt[MUL].pvx = pipe_r[PN].vx * pipe_r[PN].nx;
    pipe_nxt[MUL].pvy = pipe_r[PN].vy * pipe_r[PN].ny;
  end

  // projected position and normal velocity sum
  always_comb begin : c_r1
    logic signed [2*W+1:0] rx;
    logic signed [2*W+1:0] ry;
    rx = rnd_sh((2*W+2)'(pipe_r[MUL].pxr), NORM);
    ry = rnd_sh((2*W+2)'(pipe_r[MUL].pyr), NORM);
    pipe_nxt[R1]      = pipe_r[MUL];
    pipe_nxt[R1].px   = $signed({3'b000, cx_r}) + $signed(rx[W+1:0]);
    pipe_nxt[R1].py   = $signed({3'b000, cy_r}) + $signed(ry[W+1:0]);
    pipe_nxt[R1].vsum = pipe_r[MUL].pvx + pipe_r[MUL].pvy;
  end

  always_comb begin : c_r2
    logic signed [2*W+1:0] rv;
    rv = rnd_sh((2*W+2)'(pipe_r[R1].vsum), NORM);
    pipe_nxt[R2]    = pipe_r[R1];
    pipe_nxt[R2].vn = rv[W+1:0];
  end

  always_comb begin : c_m2
    pipe_nxt[M2]     = pipe_r[R2];
    pipe_nxt[M2].pdx = pipe_r[R2].vn * pipe_r[R2].nx;
    pipe_nxt[M2].pdy = pipe_r[R2].vn * pipe_r[R2].ny;
  end

  // free-slip reflection of the inward normal component
  always_comb begin : c_r3
    logic signed [2*W+1:0] dvx;
    logic signed [2*W+1:0] dvy;
    dvx = rnd_sh(pipe_r[M2].pdx, NORM - 1);
    dvy = rnd_sh(pipe_r[M2].pdy, NORM - 1);
    pipe_nxt[R3] = pipe_r[M2];
    if (pipe_r[M2].vn[W+1]) begin
      pipe_nxt[R3].nvx = sat_w((W+4)'(pipe_r[M2].vx) - (W+4)'($signed(dvx[W+1:0])));
      pipe_nxt[R3].nvy = sat_w((W+4)'(pipe_r[M2].vy) - (W+4)'($signed(dvy[W+1:0])));
    end else begin
      pipe_nxt[R3].nvx = pipe_r[M2].vx;
      pipe_nxt[R3].nvy = pipe_r[M2].vy;
    end
  end

  // result selection into the output register
  always_comb begin : c_out
    pipe_nxt[OUT] = pipe_r[R3];
    if (pipe_r[R3].dom && pipe_r[R3].hit) begin
      if (pipe_r[R3].center) begin
        pipe_nxt[OUT].x = sat_w($signed((W+4)'(cx_r) + (W+4)'(rad_r)));
        pipe_nxt[OUT].y = $signed({1'b0, cy_r});
      end else begin
        pipe_nxt[OUT].x  = sat_w((W+4)'(pipe_r[R3].px));
        pipe_nxt[OUT].y  = sat_w((W+4)'(pipe_r[R3].py));
        pipe_nxt[OUT].vx = pipe_r[R3].nvx;
        pipe_nxt[OUT].vy = pipe_r[R3].nvy;
      end
    end
  end

  assign out_valid     = v_r[OUT];
  assign out_in_domain = pipe_r[OUT].dom;
  assign out_new_x     = pipe_r[OUT].x;
  assign out_new_y     = pipe_r[OUT].y;
  assign out_new_vx    = pipe_r[OUT].vx;
  assign out_new_vy    = pipe_r[OUT].vy;

  a_out_of_domain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_domain |->
      (out_new_x[W-1] || ({1'b0, out_new_x} >= {2'b00, lx_r})))
    else $error("out of domain result has x inside the domain");

  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[SQEND] && pipe_r[SQEND].dom && pipe_r[SQEND].hit && !pipe_r[SQEND].center |->
      (pipe_r[SQEND].root[W-1 -: 2] != 2'b00))
    else $error("root of normalized offset below range");

  a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[PN] && pipe_r[PN].dom && pipe_r[PN].hit && !pipe_r[PN].center |->
      ((pipe_r[PN].nx <= N_ONE) && (pipe_r[PN].nx >= -N_ONE) &&
       (pipe_r[PN].ny <= N_ONE) && (pipe_r[PN].ny >= -N_ONE)))
    else $error("unit normal component beyond one");

endmodule

`default_nettype wire
